// ===== src/rilp_pkg.sv =====
`timescale 1ns / 1ps

package rilp_pkg;

    localparam int VALUE_W  = 63;
    localparam int STATUS_W = 2;
    localparam int MODE_W   = 3;
    localparam int CHAR_W   = 8;

    // Base mode register codes.
    localparam logic [MODE_W-1:0] MODE_AUTO = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BIN  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_OCT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEC  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_HEX  = 3'd4;

    // Characters that matter to the prefix and digit decode.
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CH_B     = 8'h62;
    localparam logic [CHAR_W-1:0] CH_O     = 8'h6f;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;

    typedef enum logic [1:0] {
        RADIX_2  = 2'd0,
        RADIX_8  = 2'd1,
        RADIX_10 = 2'd2,
        RADIX_16 = 2'd3
    } radix_t;

    typedef enum logic [STATUS_W-1:0] {
        ERR_NONE     = 2'd0,
        ERR_OVERFLOW = 2'd1,
        ERR_FAILURE  = 2'd2
    } err_t;

    // Per-literal parse state.
    typedef struct packed {
        logic [VALUE_W-1:0] acc;
        logic [1:0]         pos;
        logic               first_zero;
        radix_t             radix;
        logic               digit_seen;
        err_t               err;
        logic [MODE_W-1:0]  mode_held;
    } lit_state_t;

    localparam lit_state_t LIT_CLEAR = '{
        acc:        '0,
        pos:        2'd0,
        first_zero: 1'b0,
        radix:      RADIX_10,
        digit_seen: 1'b0,
        err:        ERR_NONE,
        mode_held:  MODE_AUTO
    };

endpackage

// ===== src/rilp_step.sv =====
`timescale 1ns / 1ps

// One character of parsing: next literal state and, on the last character,
// the status and value of the finished literal.
module rilp_step (
    input  rilp_pkg::lit_state_t           cur,
    input  logic [rilp_pkg::CHAR_W-1:0]    char_code,
    input  logic                           is_last,
    input  logic [rilp_pkg::MODE_W-1:0]    base_mode,
    output rilp_pkg::lit_state_t           nxt,
    output logic [rilp_pkg::STATUS_W-1:0]  status,
    output logic [rilp_pkg::VALUE_W-1:0]   value
);
    import rilp_pkg::*;

    lit_state_t          s;
    logic [4:0]          dig;
    logic                dig_ok;
    logic                pfx_hit;
    radix_t              pfx_radix;
    logic [VALUE_W+3:0]  dec_sum;
    err_t                st;

    // Raw digit value; 16 marks a character that is no digit at all.
    always_comb begin
        dig = 5'd16;
        if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
            dig = 5'(char_code - CH_ZERO);
        end else if (char_code >= CH_LA && char_code <= CH_LF) begin
            dig = 5'(char_code - CH_LA) + 5'd10;
        end else if (char_code >= CH_UA && char_code <= CH_UF) begin
            dig = 5'(char_code - CH_UA) + 5'd10;
        end
    end

    // Prefix check for the second character; auto mode also picks the radix.
    always_comb begin
        pfx_hit   = 1'b0;
        pfx_radix = cur.radix;
        case (cur.mode_held)
            MODE_AUTO: begin
                if (char_code == CH_B) begin
                    pfx_hit   = 1'b1;
                    pfx_radix = RADIX_2;
                end else if (char_code == CH_O) begin
                    pfx_hit   = 1'b1;
                    pfx_radix = RADIX_8;
                end else if (char_code == CH_X) begin
                    pfx_hit   = 1'b1;
                    pfx_radix = RADIX_16;
                end
            end
            MODE_BIN: pfx_hit = (char_code == CH_B);
            MODE_OCT: pfx_hit = (char_code == CH_O);
            MODE_HEX: pfx_hit = (char_code == CH_X);
            default:  pfx_hit = 1'b0;
        endcase
        pfx_hit = pfx_hit && cur.first_zero && (cur.pos == 2'd1);
    end

    // acc * 10 + digit as a shift-add, wide enough to see any carry out.
    assign dec_sum = {1'b0, cur.acc, 3'b0} + {3'b0, cur.acc, 1'b0}
                     + {(VALUE_W-1)'(0), dig};

    always_comb begin
        s = cur;

        if (cur.pos == 2'd0) begin
            s.mode_held  = base_mode;
            s.first_zero = (char_code == CH_ZERO);
            unique case (base_mode)
                MODE_AUTO: s.radix = RADIX_10;
                MODE_BIN:  s.radix = RADIX_2;
                MODE_OCT:  s.radix = RADIX_8;
                MODE_DEC:  s.radix = RADIX_10;
                MODE_HEX:  s.radix = RADIX_16;
                default:   s.err   = ERR_FAILURE;
            endcase
        end

        case (s.radix)
            RADIX_2:  dig_ok = (dig <= 5'd1);
            RADIX_8:  dig_ok = (dig <= 5'd7);
            RADIX_10: dig_ok = (dig <= 5'd9);
            default:  dig_ok = (dig <= 5'd15);
        endcase

        if (s.err == ERR_NONE) begin
            if (pfx_hit) begin
                s.acc        = '0;
                s.digit_seen = 1'b0;
                s.radix      = pfx_radix;
            end else if (!dig_ok) begin
                s.err = ERR_FAILURE;
            end else begin
                s.digit_seen = 1'b1;
                case (s.radix)
                    RADIX_2: begin
                        if (cur.acc[VALUE_W-1]) begin
                            s.err = ERR_OVERFLOW;
                        end else begin
                            s.acc = {cur.acc[VALUE_W-2:0], dig[0]};
                        end
                    end
                    RADIX_8: begin
                        if (cur.acc[VALUE_W-1:VALUE_W-3] != 3'd0) begin
                            s.err = ERR_OVERFLOW;
                        end else begin
                            s.acc = {cur.acc[VALUE_W-4:0], dig[2:0]};
                        end
                    end
                    RADIX_16: begin
                        if (cur.acc[VALUE_W-1:VALUE_W-4] != 4'd0) begin
                            s.err = ERR_OVERFLOW;
                        end else begin
                            s.acc = {cur.acc[VALUE_W-5:0], dig[3:0]};
                        end
                    end
                    default: begin
                        if (dec_sum[VALUE_W+3:VALUE_W] != 4'd0) begin
                            s.err = ERR_OVERFLOW;
                        end else begin
                            s.acc = dec_sum[VALUE_W-1:0];
                        end
                    end
                endcase
            end
        end

        if (s.pos != 2'd2) begin
            s.pos = s.pos + 2'd1;
        end

        st = s.err;
        if (st == ERR_NONE && !s.digit_seen) begin
            st = ERR_FAILURE;
        end
        status = st;
        value  = (st == ERR_NONE) ? s.acc : '0;

        nxt = is_last ? LIT_CLEAR : s;
    end

endmodule

// ===== src/radix_integer_literal_parser.sv =====
`timescale 1ns / 1ps

// Path: a last character accepted on s_* passes the input register, then the
// result register, before its result shows on m_* (a stall on m_ready can wait).
// Throughput: one character per cycle unless stalled; a result that waits for
// m_ready holds back the next last character and every character after it.
// Reset: aresetn is synchronous and active low; it empties both registers,
// clears the literal state and sets base_mode to auto.
module radix_integer_literal_parser (
    input  logic                           aclk,
    input  logic                           aresetn,

    // Base mode register write port.
    input  logic                           cfg_wr_en,
    input  logic [rilp_pkg::MODE_W-1:0]    cfg_wr_data,

    // Character stream.
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [rilp_pkg::CHAR_W-1:0]    s_char_code,
    input  logic                           s_is_last,

    // Literal results.
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [rilp_pkg::STATUS_W-1:0]  m_status,
    output logic [rilp_pkg::VALUE_W-1:0]   m_value
);
    import rilp_pkg::*;

    logic [MODE_W-1:0]   base_mode_reg;

    // Input register: holds one character until the parse stage takes it.
    logic                in_valid_reg;
    logic [CHAR_W-1:0]   in_char_reg;
    logic                in_last_reg;

    // Literal state carried from one character to the next.
    lit_state_t          lit_reg;
    lit_state_t          lit_next;

    // Result register.
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [VALUE_W-1:0]  out_value_reg;

    logic [STATUS_W-1:0] step_status;
    logic [VALUE_W-1:0]  step_value;
    logic                out_free;
    logic                advance;

    rilp_step u_step (
        .cur       (lit_reg),
        .char_code (in_char_reg),
        .is_last   (in_last_reg),
        .base_mode (base_mode_reg),
        .nxt       (lit_next),
        .status    (step_status),
        .value     (step_value)
    );

    // The result register can take a new result when it is empty or being
    // drained this cycle. Only a last character needs it; every other
    // character moves through the parse stage regardless of m_ready.
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_mode_reg <= MODE_AUTO;
            in_valid_reg  <= 1'b0;
            lit_reg       <= LIT_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                base_mode_reg <= cfg_wr_data;
            end

            if (s_ready) begin
                in_valid_reg <= s_valid;
            end

            if (advance) begin
                lit_reg <= lit_next;
            end

            // A finished literal loads the result register; otherwise it
            // empties once the consumer has taken the item.
            if (advance && in_last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_code;
            in_last_reg <= s_is_last;
        end
        if (advance && in_last_reg) begin
            out_status_reg <= step_status;
            out_value_reg  <= step_value;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_status = out_status_reg;
    assign m_value  = out_value_reg;

endmodule

// ===== src/rilp_checker.sv =====
`timescale 1ns / 1ps

module rilp_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [rilp_pkg::STATUS_W-1:0]  m_status,
    input logic [rilp_pkg::VALUE_W-1:0]   m_value
);
    import rilp_pkg::*;

    // A result that is not taken stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_value))
        else $error("result changed while stalled");

    // Only a successful literal carries a value.
    a_zero_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ERR_OVERFLOW || m_status == ERR_FAILURE)
        |-> m_value == '0)
        else $error("nonzero value with an error status");

    // The status code never takes its unused encoding.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ERR_NONE || m_status == ERR_OVERFLOW
                     || m_status == ERR_FAILURE))
        else $error("undefined status code");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

endmodule

bind radix_integer_literal_parser rilp_checker u_rilp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_status (m_status),
    .m_value  (m_value)
);
